[rtl/core/source_tokenizer_unit_assert.svh]
// Assertion macros for the source tokenizer.
// STU_ASSERT_IMP checks a same-cycle implication, STU_ASSERT_NXT a next-cycle one.
`ifndef SOURCE_TOKENIZER_UNIT_ASSERT_SVH
`define SOURCE_TOKENIZER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define STU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define STU_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define STU_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define STU_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/core/stu_pkg.sv]
`default_nettype none

package stu_pkg;

  // token codes
  localparam logic [4:0] TK_END    = 5'd0;
  localparam logic [4:0] TK_NUMBER = 5'd1;
  localparam logic [4:0] TK_IDENT  = 5'd2;
  localparam logic [4:0] TK_RETURN = 5'd3;
  localparam logic [4:0] TK_LET    = 5'd4;
  localparam logic [4:0] TK_EQEQ   = 5'd5;
  localparam logic [4:0] TK_NE     = 5'd6;
  localparam logic [4:0] TK_LT     = 5'd7;
  localparam logic [4:0] TK_GT     = 5'd8;
  localparam logic [4:0] TK_LE     = 5'd9;
  localparam logic [4:0] TK_GE     = 5'd10;
  localparam logic [4:0] TK_ASSIGN = 5'd11;
  localparam logic [4:0] TK_PLUS   = 5'd12;
  localparam logic [4:0] TK_MINUS  = 5'd13;
  localparam logic [4:0] TK_STAR   = 5'd14;
  localparam logic [4:0] TK_SLASH  = 5'd15;
  localparam logic [4:0] TK_LPAREN = 5'd16;
  localparam logic [4:0] TK_RPAREN = 5'd17;
  localparam logic [4:0] TK_SEMI   = 5'd18;

  localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

  // scan modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_NUMBER = 2'd1;
  localparam logic [1:0] MODE_IDENT  = 2'd2;
  localparam logic [1:0] MODE_OPER   = 2'd3;

  // pending operator
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_EQ   = 3'd1;
  localparam logic [2:0] OP_BANG = 3'd2;
  localparam logic [2:0] OP_LT   = 3'd3;
  localparam logic [2:0] OP_GT   = 3'd4;

  // output word source select
  localparam logic [2:0] SEL_PAIR    = 3'd0;
  localparam logic [2:0] SEL_OPFIN   = 3'd1;
  localparam logic [2:0] SEL_NUMBER  = 3'd2;
  localparam logic [2:0] SEL_KEYWORD = 3'd3;
  localparam logic [2:0] SEL_CHUNK   = 3'd4;
  localparam logic [2:0] SEL_START   = 3'd5;

  typedef struct packed {
    logic       take_byte;
    logic       clear_all;
    logic       acc_step;
    logic       id_append;
    logic       finish_clear;
    logic       set_stop;
    logic       start_tok;
    logic       chunk_init;
    logic       chunk_next;
    logic       out_load;
    logic [2:0] out_sel;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       stopped;
    logic       is_eq;
    logic       is_digit;
    logic       is_word;
    logic       start_emits;
    logic       pend_bang;
    logic       keyword;
    logic       chunk_final;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

[rtl/core/source_tokenizer_unit.sv]
// Streaming lexer: one source byte per input word, tokens out as result words.
// A word with kind 0 restarts the source and clears all scan state; it gives no
// result. Whitespace is skipped, numbers saturate at 2^31-1, identifiers keep
// their first MAX_IDENT_CHARS characters and leave as 8-character chunks
// (first character in the low byte), "return" and "let" come out as keywords.
// Byte 0, an unknown byte or a '!' not followed by '=' gives an end token and
// the block ignores bytes until the next restart. When a byte ends an
// identifier that is not a keyword, the controller walks the identifier store
// one 8-byte row per read with a registered read port and gives one result
// word per chunk. An output stall holds the controller until the output
// register is free. A new byte is taken only after the last result word of
// the previous one is in the output register, so up to one result may wait
// there while the next byte is taken. No clearing pass is needed after reset.
`default_nettype none
`include "source_tokenizer_unit_assert.svh"

module source_tokenizer_unit #(
  parameter int unsigned MAX_IDENT_CHARS = 63
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // source byte channel
  input  wire logic        src_valid,
  output logic             src_stall,
  input  wire logic        kind,
  input  wire logic [7:0]  source_byte,
  // token channel
  output logic             tok_valid,
  input  wire logic        tok_stall,
  output logic [4:0]       token_kind,
  output logic [30:0]      number_value,
  output logic [63:0]      text_chunk,
  output logic [3:0]       chunk_length,
  output logic             token_end,
  output logic             last
);

  stu_pkg::cmd_t cmd;
  stu_pkg::sts_t sts;

  // sequencing: accept, classify, finish the open token, start the new one
  stu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .kind      (kind),
    .src_stall (src_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // scan state, identifier store, number accumulator, output register
  stu_datapath #(
    .MAX_IDENT_CHARS (MAX_IDENT_CHARS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .source_byte  (source_byte),
    .tok_stall    (tok_stall),
    .tok_valid    (tok_valid),
    .token_kind   (token_kind),
    .number_value (number_value),
    .text_chunk   (text_chunk),
    .chunk_length (chunk_length),
    .token_end    (token_end),
    .last         (last)
  );

  // token code stays in the defined range
  `STU_ASSERT_IMP(a_tok_range, clk, rst, tok_valid, token_kind <= stu_pkg::TK_SEMI, "bad token code")
  // identifier chunks carry 1..8 characters
  `STU_ASSERT_IMP(a_chunk_len, clk, rst, tok_valid && (token_kind == stu_pkg::TK_IDENT), (chunk_length != 4'd0) && (chunk_length <= 4'd8), "bad chunk length")
  // every other token is a single word with no text
  `STU_ASSERT_IMP(a_single_word, clk, rst, tok_valid && (token_kind != stu_pkg::TK_IDENT), token_end && (chunk_length == 4'd0), "non-identifier token split")
  // a restart word always releases a stopped scanner
  `STU_ASSERT_NXT(a_restart, clk, rst, src_valid && !src_stall && !kind, !sts.stopped && (sts.mode == stu_pkg::MODE_IDLE), "restart did not clear state")

endmodule

`default_nettype wire

[rtl/core/stu_ctrl.sv]
`default_nettype none

module stu_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          src_valid,
  input  wire logic          kind,
  output logic               src_stall,
  input  wire stu_pkg::sts_t sts,
  output stu_pkg::cmd_t      cmd
);

  localparam logic [2:0] ST_WAIT  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_FETCH = 3'd3;
  localparam logic [2:0] ST_CHUNK = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign src_stall = (state != ST_WAIT);
  assign accept    = src_valid && !src_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_WAIT: begin
        if (accept) begin
          cmd.take_byte = 1'b1;
          if (!kind) begin
            cmd.clear_all = 1'b1;
          end else if (!sts.stopped) begin
            state_next = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        case (sts.mode)
          stu_pkg::MODE_OPER: begin
            if (sts.out_free) begin
              cmd.out_load     = 1'b1;
              cmd.finish_clear = 1'b1;
              if (sts.is_eq) begin
                cmd.out_sel  = stu_pkg::SEL_PAIR;
                cmd.out_last = 1'b1;
                state_next   = ST_WAIT;
              end else begin
                cmd.out_sel  = stu_pkg::SEL_OPFIN;
                cmd.out_last = sts.pend_bang || !sts.start_emits;
                if (sts.pend_bang) begin
                  // lone '!': the byte after it is dropped
                  cmd.set_stop = 1'b1;
                  state_next   = ST_WAIT;
                end else begin
                  state_next = ST_START;
                end
              end
            end
          end
          stu_pkg::MODE_NUMBER: begin
            if (sts.is_digit) begin
              cmd.acc_step = 1'b1;
              state_next   = ST_WAIT;
            end else if (sts.out_free) begin
              cmd.out_load     = 1'b1;
              cmd.out_sel      = stu_pkg::SEL_NUMBER;
              cmd.out_last     = !sts.start_emits;
              cmd.finish_clear = 1'b1;
              state_next       = ST_START;
            end
          end
          stu_pkg::MODE_IDENT: begin
            if (sts.is_word) begin
              cmd.id_append = 1'b1;
              state_next    = ST_WAIT;
            end else if (sts.keyword) begin
              if (sts.out_free) begin
                cmd.out_load     = 1'b1;
                cmd.out_sel      = stu_pkg::SEL_KEYWORD;
                cmd.out_last     = !sts.start_emits;
                cmd.finish_clear = 1'b1;
                state_next       = ST_START;
              end
            end else begin
              cmd.chunk_init = 1'b1;
              state_next     = ST_FETCH;
            end
          end
          default: begin
            state_next = ST_START;
          end
        endcase
      end
      ST_START: begin
        if (sts.start_emits) begin
          if (sts.out_free) begin
            cmd.out_load  = 1'b1;
            cmd.out_sel   = stu_pkg::SEL_START;
            cmd.out_last  = 1'b1;
            cmd.start_tok = 1'b1;
            state_next    = ST_WAIT;
          end
        end else begin
          cmd.start_tok = 1'b1;
          state_next    = ST_WAIT;
        end
      end
      ST_FETCH: begin
        state_next = ST_CHUNK;
      end
      ST_CHUNK: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = stu_pkg::SEL_CHUNK;
          cmd.out_last = sts.chunk_final && !sts.start_emits;
          if (sts.chunk_final) begin
            cmd.finish_clear = 1'b1;
            state_next       = ST_START;
          end else begin
            cmd.chunk_next = 1'b1;
            state_next     = ST_FETCH;
          end
        end
      end
      default: begin
        state_next = ST_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WAIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/stu_datapath.sv]
`default_nettype none

module stu_datapath #(
  parameter int unsigned MAX_IDENT_CHARS = 63
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire stu_pkg::cmd_t cmd,
  output stu_pkg::sts_t      sts,
  input  wire logic [7:0]    source_byte,
  input  wire logic          tok_stall,
  output logic               tok_valid,
  output logic [4:0]         token_kind,
  output logic [30:0]        number_value,
  output logic [63:0]        text_chunk,
  output logic [3:0]         chunk_length,
  output logic               token_end,
  output logic               last
);

  localparam int unsigned LEN_W   = $clog2(MAX_IDENT_CHARS + 1);
  localparam int unsigned ROWS    = (MAX_IDENT_CHARS + 7) / 8;
  localparam int unsigned ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned SUM_W   = ((LEN_W > ROW_W + 3) ? LEN_W : ROW_W + 3) + 1;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_IDENT_CHARS);

  function automatic logic [7:0] ret_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = "r";
      3'd1:    c = "e";
      3'd2:    c = "t";
      3'd3:    c = "u";
      3'd4:    c = "r";
      3'd5:    c = "n";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] let_char(input logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0:    c = "l";
      2'd1:    c = "e";
      2'd2:    c = "t";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  logic [7:0]       cur_byte;
  logic [1:0]       mode;
  logic [2:0]       pend;
  logic [30:0]      acc;
  logic [LEN_W-1:0] id_len;
  logic             ret_match;
  logic             let_match;
  logic             stopped;
  logic [ROW_W-1:0] chunk_row;
  logic [63:0]      id_mem [ROWS];
  logic [63:0]      row_data;

  // byte classes
  logic       is_digit, is_alpha, is_word_start, is_word, is_space, is_opstart;
  logic       start_emits;
  logic [4:0] start_code;
  logic [2:0] start_op;
  logic [3:0] digit;

  always_comb begin
    is_digit      = (cur_byte >= "0") && (cur_byte <= "9");
    is_alpha      = ((cur_byte >= "a") && (cur_byte <= "z")) ||
                    ((cur_byte >= "A") && (cur_byte <= "Z"));
    is_word_start = is_alpha || (cur_byte == "_");
    is_word       = is_word_start || is_digit;
    is_space      = (cur_byte == " ") || (cur_byte == 8'h0A) || (cur_byte == 8'h09);
    is_opstart    = (cur_byte == "=") || (cur_byte == "!") ||
                    (cur_byte == "<") || (cur_byte == ">");
    start_emits   = !is_space && !is_word && !is_opstart;
    digit         = cur_byte[3:0];
    case (cur_byte)
      "+":     start_code = stu_pkg::TK_PLUS;
      "-":     start_code = stu_pkg::TK_MINUS;
      "*":     start_code = stu_pkg::TK_STAR;
      "/":     start_code = stu_pkg::TK_SLASH;
      "(":     start_code = stu_pkg::TK_LPAREN;
      ")":     start_code = stu_pkg::TK_RPAREN;
      ";":     start_code = stu_pkg::TK_SEMI;
      default: start_code = stu_pkg::TK_END;
    endcase
    case (cur_byte)
      "=":     start_op = stu_pkg::OP_EQ;
      "!":     start_op = stu_pkg::OP_BANG;
      "<":     start_op = stu_pkg::OP_LT;
      ">":     start_op = stu_pkg::OP_GT;
      default: start_op = stu_pkg::OP_NONE;
    endcase
  end

  // acc * 10 + d, saturating
  logic [34:0] acc_wide;
  logic [30:0] acc_sat;

  assign acc_wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {31'b0, digit};
  assign acc_sat  = (acc_wide > {4'b0, stu_pkg::NUM_MAX}) ? stu_pkg::NUM_MAX : acc_wide[30:0];

  // keyword detect
  logic       ret_hit, let_hit, keyword;
  logic [4:0] kw_code;

  assign ret_hit = ret_match && (id_len == LEN_W'(6));
  assign let_hit = let_match && (id_len == LEN_W'(3));
  assign keyword = ret_hit || let_hit;
  assign kw_code = ret_hit ? stu_pkg::TK_RETURN : stu_pkg::TK_LET;

  // chunk slicing
  logic [SUM_W-1:0] remaining;
  logic             chunk_final;
  logic [3:0]       chunk_n;
  logic [63:0]      chunk_masked;

  always_comb begin
    remaining   = SUM_W'(id_len) - SUM_W'({chunk_row, 3'b000});
    chunk_final = (remaining <= SUM_W'(8));
    chunk_n     = chunk_final ? remaining[3:0] : 4'd8;
    for (int k = 0; k < 8; k++) begin
      chunk_masked[8*k +: 8] = (4'(k) < chunk_n) ? row_data[8*k +: 8] : 8'h00;
    end
  end

  // operator codes
  logic [4:0] pair_code, opfin_code;

  always_comb begin
    case (pend)
      stu_pkg::OP_EQ:   begin pair_code = stu_pkg::TK_EQEQ; opfin_code = stu_pkg::TK_ASSIGN; end
      stu_pkg::OP_BANG: begin pair_code = stu_pkg::TK_NE;   opfin_code = stu_pkg::TK_END;    end
      stu_pkg::OP_LT:   begin pair_code = stu_pkg::TK_LE;   opfin_code = stu_pkg::TK_LT;     end
      stu_pkg::OP_GT:   begin pair_code = stu_pkg::TK_GE;   opfin_code = stu_pkg::TK_GT;     end
      default:          begin pair_code = stu_pkg::TK_GE;   opfin_code = stu_pkg::TK_END;    end
    endcase
  end

  // identifier memory, one row per chunk, byte writes
  logic             wr_en;
  logic [ROW_W-1:0] wr_row;
  logic [2:0]       wr_lane;

  assign wr_en   = (cmd.id_append && (id_len < LEN_MAX)) || (cmd.start_tok && is_word_start);
  assign wr_row  = cmd.start_tok ? '0 : ROW_W'(id_len >> 3);
  assign wr_lane = cmd.start_tok ? 3'd0 : id_len[2:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[wr_row][{wr_lane, 3'b000} +: 8] <= cur_byte;
    end
    row_data <= id_mem[chunk_row];
  end

  // scan state
  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      cur_byte <= source_byte;
    end
    if (cmd.chunk_init) begin
      chunk_row <= '0;
    end else if (cmd.chunk_next) begin
      chunk_row <= chunk_row + 1'b1;
    end
    if (cmd.id_append) begin
      ret_match <= ret_match && (id_len < LEN_W'(6)) && (cur_byte == ret_char(id_len[2:0]));
      let_match <= let_match && (id_len < LEN_W'(3)) && (cur_byte == let_char(id_len[1:0]));
    end else if (cmd.start_tok) begin
      ret_match <= (cur_byte == "r");
      let_match <= (cur_byte == "l");
    end

    if (rst || cmd.clear_all) begin
      mode    <= stu_pkg::MODE_IDLE;
      pend    <= stu_pkg::OP_NONE;
      acc     <= '0;
      id_len  <= '0;
      stopped <= 1'b0;
    end else begin
      if (cmd.finish_clear) begin
        mode   <= stu_pkg::MODE_IDLE;
        pend   <= stu_pkg::OP_NONE;
        acc    <= '0;
        id_len <= '0;
      end
      if (cmd.set_stop) begin
        stopped <= 1'b1;
      end
      if (cmd.acc_step) begin
        acc <= acc_sat;
      end
      if (cmd.id_append && (id_len < LEN_MAX)) begin
        id_len <= id_len + 1'b1;
      end
      if (cmd.start_tok) begin
        if (is_digit) begin
          mode <= stu_pkg::MODE_NUMBER;
          acc  <= {27'b0, digit};
        end else if (is_word_start) begin
          mode   <= stu_pkg::MODE_IDENT;
          id_len <= LEN_W'(1);
        end else if (is_opstart) begin
          mode <= stu_pkg::MODE_OPER;
          pend <= start_op;
        end else if (start_emits && (start_code == stu_pkg::TK_END)) begin
          stopped <= 1'b1;
        end
      end
    end
  end

  // output register
  logic        out_free;
  logic [4:0]  token_kind_next;
  logic [30:0] number_value_next;
  logic [63:0] text_chunk_next;
  logic [3:0]  chunk_length_next;
  logic        token_end_next;

  assign out_free = !tok_valid || !tok_stall;

  always_comb begin
    number_value_next = '0;
    text_chunk_next   = '0;
    chunk_length_next = '0;
    token_end_next    = 1'b1;
    case (cmd.out_sel)
      stu_pkg::SEL_PAIR:    token_kind_next = pair_code;
      stu_pkg::SEL_OPFIN:   token_kind_next = opfin_code;
      stu_pkg::SEL_NUMBER: begin
        token_kind_next   = stu_pkg::TK_NUMBER;
        number_value_next = acc;
      end
      stu_pkg::SEL_KEYWORD: token_kind_next = kw_code;
      stu_pkg::SEL_CHUNK: begin
        token_kind_next   = stu_pkg::TK_IDENT;
        text_chunk_next   = chunk_masked;
        chunk_length_next = chunk_n;
        token_end_next    = chunk_final;
      end
      default:              token_kind_next = start_code;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (cmd.out_load) begin
      tok_valid <= 1'b1;
    end else if (!tok_stall) begin
      tok_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      token_kind   <= token_kind_next;
      number_value <= number_value_next;
      text_chunk   <= text_chunk_next;
      chunk_length <= chunk_length_next;
      token_end    <= token_end_next;
      last         <= cmd.out_last;
    end
  end

  always_comb begin
    sts.mode        = mode;
    sts.stopped     = stopped;
    sts.is_eq       = (cur_byte == "=");
    sts.is_digit    = is_digit;
    sts.is_word     = is_word;
    sts.start_emits = start_emits;
    sts.pend_bang   = (pend == stu_pkg::OP_BANG);
    sts.keyword     = keyword;
    sts.chunk_final = chunk_final;
    sts.out_free    = out_free;
  end

endmodule

`default_nettype wire
